[rtl/core/spll_pkg.sv]
// Shared constants, register indexes and sine table generator for the single-phase PLL.
`timescale 1ns / 1ps

package spll_pkg;

    // Default quarter-wave table depth
    localparam int SINE_TABLE_DEPTH_DEFAULT = 256;

    // Q30 constants for the table series
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_Q30    = ONE_Q30 / 2;
    localparam longint SINE_SCALE  = 64'sd32767;

    // Taylor series divisors (2n)(2n+1) for n = 1..7
    localparam longint TAYLOR_DIV [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                          64'sd110, 64'sd156, 64'sd210};

    // Full-scale table value, also used past the end of the quarter wave
    localparam logic [15:0] SINE_MAX = 16'd32767;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOGI_ERROR_GAIN   = 3'd0,
        CFG_SOGI_RATE         = 3'd1,
        CFG_CENTER_PHASE_STEP = 3'd2,
        CFG_PROP_GAIN         = 3'd3,
        CFG_INTEG_GAIN        = 3'd4
    } cfg_index_t;

    // Register reset values
    localparam logic [17:0] SOGI_ERROR_GAIN_RST   = 18'd58222;
    localparam logic [17:0] SOGI_RATE_RST         = 18'd41175;
    localparam logic [31:0] CENTER_PHASE_STEP_RST = 32'd429496730;
    localparam logic [15:0] PROP_GAIN_RST         = 16'd171;
    localparam logic [15:0] INTEG_GAIN_RST        = 16'd560;

    // Quarter turn in phase units
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Evaluate one table entry from its Q30 angle (elaboration only)
    function automatic logic [15:0] sine_series(input longint t);
        longint term;
        longint sum;
        term = t;
        sum  = t;
        for (int n = 0; n < 7; n++)
        begin
            term = -((term * t) / ONE_Q30);
            term = (term * t) / ONE_Q30;
            term = term / TAYLOR_DIV[n];
            sum  = sum + term;
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        return 16'((sum * SINE_SCALE + HALF_Q30) / ONE_Q30);
    endfunction

endpackage

[rtl/core/spll_sine_rom.sv]
// Quarter-wave sine table with quadrant folding and a registered signed Q1.15 output.
`timescale 1ns / 1ps

module spll_sine_rom #(
    parameter int DEPTH = spll_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic [31:0]        phase,
    output logic signed [15:0] value
);

    localparam int AW = $clog2(DEPTH);
    localparam int KW = $clog2(DEPTH + 1);

    logic [15:0]        rom [DEPTH];
    logic [29+KW:0]     scaled;
    logic [AW-1:0]      idx;
    logic [KW-1:0]      k;
    logic [15:0]        mag;
    logic signed [15:0] value_next;
    logic signed [15:0] value_reg;

    // Build the constant table entry by entry
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        localparam longint ANGLE = (longint'(i) * spll_pkg::HALF_PI_Q30) / DEPTH;
        assign rom[i] = spll_pkg::sine_series(ANGLE);
    end

    // Fold the phase into a table index, mirror odd quadrants, negate the lower half
    always_comb
    begin
        scaled = (30 + KW)'(phase[29:0]) * (30 + KW)'(DEPTH);
        idx    = scaled[29+AW:30];
        k      = phase[30] ? (KW'(DEPTH) - KW'(idx)) : KW'(idx);
        mag    = (k >= KW'(DEPTH)) ? spll_pkg::SINE_MAX : rom[k[AW-1:0]];
        value_next = phase[31] ? -$signed(mag) : $signed(mag);
    end

    // Register the lookup
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/core/sogi_single_phase_pll.sv]
// Top level: quadrature generator, Park q error, PI loop and phase accumulator.
// Samples are taken only in S_IDLE; each then passes S_MUL_A, S_UPD_A, S_MUL_B, S_UPD_B,
// S_MUL_S, S_MUL_C, S_SUM_Q, S_MUL_I, S_MUL_P and S_STEP, where its result is registered.
// One shared 26x19 multiplier serves six products in sequence, with add-and-saturate cycles
// between dependent products. A finished result waits in an output register; the block
// takes the next sample meanwhile. Reset (rst_n low, asynchronous): filter states, integral
// and phase clear to zero, configuration registers return to their defaults.
`timescale 1ns / 1ps

module sogi_single_phase_pll #(
    parameter int SINE_TABLE_DEPTH = spll_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample channel
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [15:0]                  sample,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [31:0]                         phase,
    output logic [31:0]                         freq_step,
    output logic signed [23:0]                  alpha_out,
    output logic signed [23:0]                  beta_out,
    output logic signed [23:0]                  phase_error,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spll_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MUL_A = 11'b000_0000_0010,
        S_UPD_A = 11'b000_0000_0100,
        S_MUL_B = 11'b000_0000_1000,
        S_UPD_B = 11'b000_0001_0000,
        S_MUL_S = 11'b000_0010_0000,
        S_MUL_C = 11'b000_0100_0000,
        S_SUM_Q = 11'b000_1000_0000,
        S_MUL_I = 11'b001_0000_0000,
        S_MUL_P = 11'b010_0000_0000,
        S_STEP  = 11'b100_0000_0000
    } state_t;

    localparam logic signed [31:0] V24_MAX = 32'sd8388607;
    localparam logic signed [31:0] V24_MIN = -32'sd8388608;
    localparam logic signed [40:0] I40_MAX = 41'sd549755813887;
    localparam logic signed [40:0] I40_MIN = -41'sd549755813888;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > V24_MAX)
        begin
            r = 24'sh7F_FFFF;
        end
        else if (v < V24_MIN)
        begin
            r = -24'sh80_0000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
        logic signed [39:0] r;
        if (v > I40_MAX)
        begin
            r = 40'sh7F_FFFF_FFFF;
        end
        else if (v < I40_MIN)
        begin
            r = -40'sh80_0000_0000;
        end
        else
        begin
            r = v[39:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [17:0] err_gain_reg;
    logic [17:0] rate_reg;
    logic [31:0] center_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;

    // Loop state
    state_t             state_reg, state_next;
    logic signed [23:0] alpha_reg, alpha_next;
    logic signed [23:0] beta_reg, beta_next;
    logic signed [39:0] integral_reg, integral_next;
    logic [31:0]        phase_acc_reg, phase_acc_next;

    // Working registers
    logic signed [15:0] sample_reg;
    logic signed [15:0] sin_reg;
    logic signed [44:0] prod_reg;
    logic signed [45:0] acc_reg;
    logic signed [23:0] q_reg;

    // Output register
    logic               result_valid_reg, result_valid_next;
    logic [31:0]        phase_out_reg;
    logic [31:0]        freq_step_reg;
    logic signed [23:0] alpha_out_reg;
    logic signed [23:0] beta_out_reg;
    logic signed [23:0] q_out_reg;

    // Datapath signals
    logic signed [22:0] s_scaled;
    logic signed [25:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [44:0] mul_prod;
    logic signed [29:0] alpha_sum;
    logic signed [29:0] beta_sum;
    logic signed [45:0] q_sum;
    logic signed [45:0] q_shift;
    logic signed [40:0] integ_sum;
    logic signed [33:0] step_sum;
    logic [31:0]        step_sat;
    logic [31:0]        rom_phase;
    logic signed [15:0] rom_value;
    logic               out_free;
    logic               sample_fire;

    assign sample_ready = (state_reg == S_IDLE);
    assign sample_fire  = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;

    // Sine while idle, cosine once the request is taken; phase holds until the last step
    assign rom_phase = (state_reg == S_IDLE) ? phase_acc_reg
                                             : (phase_acc_reg + spll_pkg::QUARTER_TURN);

    spll_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk   (clk),
        .phase (rom_phase),
        .value (rom_value)
    );

    // Select operands for the shared multiplier
    always_comb
    begin
        s_scaled = {sample_reg, 7'd0};
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            S_MUL_A:
            begin
                mul_a = 26'(s_scaled) - 26'(alpha_reg);
                mul_b = {1'b0, err_gain_reg};
            end
            S_MUL_B:
            begin
                mul_a = 26'(alpha_reg) - 26'(beta_reg);
                mul_b = {1'b0, rate_reg};
            end
            S_MUL_S:
            begin
                mul_a = 26'(alpha_reg);
                mul_b = 19'(sin_reg);
            end
            S_MUL_C:
            begin
                mul_a = 26'(beta_reg);
                mul_b = 19'(rom_value);
            end
            S_MUL_I:
            begin
                mul_a = 26'(q_reg);
                mul_b = {3'd0, integ_gain_reg};
            end
            S_MUL_P:
            begin
                mul_a = 26'(q_reg);
                mul_b = {3'd0, prop_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Accumulate and saturate after each product
    always_comb
    begin
        alpha_sum = 30'(alpha_reg) + 30'(prod_reg >>> 16);
        beta_sum  = 30'(beta_reg) + 30'(prod_reg >>> 16);
        q_sum     = acc_reg + 46'(prod_reg);
        q_shift   = q_sum >>> 15;
        integ_sum = 41'(integral_reg) + 41'(prod_reg >>> 22);
        step_sum  = 34'($signed({1'b0, center_reg})) + 34'(prod_reg >>> 22)
                  + 34'(integral_reg >>> 16);
        if (step_sum < 0)
        begin
            step_sat = '0;
        end
        else if (step_sum[32])
        begin
            step_sat = '1;
        end
        else
        begin
            step_sat = step_sum[31:0];
        end
    end

    // Sequence one sample through the shared unit
    always_comb
    begin
        state_next        = state_reg;
        alpha_next        = alpha_reg;
        beta_next         = beta_reg;
        integral_next     = integral_reg;
        phase_acc_next    = phase_acc_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_fire)
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A: state_next = S_UPD_A;
            S_UPD_A:
            begin
                alpha_next = sat24(32'(alpha_sum));
                state_next = S_MUL_B;
            end
            S_MUL_B: state_next = S_UPD_B;
            S_UPD_B:
            begin
                beta_next  = sat24(32'(beta_sum));
                state_next = S_MUL_S;
            end
            S_MUL_S: state_next = S_MUL_C;
            S_MUL_C: state_next = S_SUM_Q;
            S_SUM_Q: state_next = S_MUL_I;
            S_MUL_I: state_next = S_MUL_P;
            S_MUL_P:
            begin
                integral_next = sat40(integ_sum);
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    phase_acc_next    = phase_acc_reg + step_sat;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            alpha_reg        <= '0;
            beta_reg         <= '0;
            integral_reg     <= '0;
            phase_acc_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            alpha_reg        <= alpha_next;
            beta_reg         <= beta_next;
            integral_reg     <= integral_next;
            phase_acc_reg    <= phase_acc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_gain_reg   <= spll_pkg::SOGI_ERROR_GAIN_RST;
            rate_reg       <= spll_pkg::SOGI_RATE_RST;
            center_reg     <= spll_pkg::CENTER_PHASE_STEP_RST;
            prop_gain_reg  <= spll_pkg::PROP_GAIN_RST;
            integ_gain_reg <= spll_pkg::INTEG_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (spll_pkg::cfg_index_t'(cfg_index))
                spll_pkg::CFG_SOGI_ERROR_GAIN:   err_gain_reg   <= cfg_data[17:0];
                spll_pkg::CFG_SOGI_RATE:         rate_reg       <= cfg_data[17:0];
                spll_pkg::CFG_CENTER_PHASE_STEP: center_reg     <= cfg_data;
                spll_pkg::CFG_PROP_GAIN:         prop_gain_reg  <= cfg_data[15:0];
                spll_pkg::CFG_INTEG_GAIN:        integ_gain_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // Hold the proportional product while the result waits for the output register
        if (state_reg != S_STEP)
        begin
            prod_reg <= mul_prod;
        end
        if (sample_fire)
        begin
            sample_reg <= sample;
        end
        if (state_reg == S_MUL_A)
        begin
            sin_reg <= rom_value;
        end
        if (state_reg == S_MUL_C)
        begin
            acc_reg <= -46'(prod_reg);
        end
        if (state_reg == S_SUM_Q)
        begin
            q_reg <= sat24(32'(q_shift));
        end
        if ((state_reg == S_STEP) && out_free)
        begin
            phase_out_reg <= phase_acc_reg + step_sat;
            freq_step_reg <= step_sat;
            alpha_out_reg <= alpha_reg;
            beta_out_reg  <= beta_reg;
            q_out_reg     <= q_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign phase        = phase_out_reg;
    assign freq_step    = freq_step_reg;
    assign alpha_out    = alpha_out_reg;
    assign beta_out     = beta_out_reg;
    assign phase_error  = q_out_reg;

endmodule
